// File: sv/hpp_pkg.sv
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types and constants for the server greeting packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hpp_pkg;

  // longest version string count kept, saturating
  localparam int unsigned VERSION_LEN_MAX = 255;
  localparam int unsigned STR_LEN_W       = $clog2(VERSION_LEN_MAX + 1);

  // byte counter, saturating
  localparam int unsigned BYTE_CNT_W = 25;
  localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = {BYTE_CNT_W{1'b1}};

  // header is a 3-byte length plus a sequence byte
  localparam int unsigned LEN_BYTES = 3;
  localparam int unsigned HDR_BYTES = 4;

  localparam logic [7:0] EXPECTED_VERSION_RST = 8'd10;

  // parse phases, one-hot
  typedef enum logic [10:0] {
    PH_HEADER  = 11'b000_0000_0001,
    PH_VERSION = 11'b000_0000_0010,
    PH_STRING  = 11'b000_0000_0100,
    PH_CONN    = 11'b000_0000_1000,
    PH_AUTH    = 11'b000_0001_0000,
    PH_FILLER  = 11'b000_0010_0000,
    PH_CAPLO   = 11'b000_0100_0000,
    PH_CHARSET = 11'b000_1000_0000,
    PH_STATUS  = 11'b001_0000_0000,
    PH_CAPHI   = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEN_ERR   = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_NO_TERM   = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // one parsed greeting
  typedef struct packed {
    status_t     result_status;
    logic [7:0]  version_seen;
    logic [7:0]  version_text_length;
    logic [31:0] connection_number;
    logic [63:0] auth_bytes;
    logic [31:0] capability_word;
    logic [7:0]  character_set;
    logic [15:0] server_status_word;
  } res_t;

  // one word handed from the input register to the parse core
  typedef struct packed {
    logic       take;
    logic       fin;
    logic [7:0] data;
  } ctl_t;

endpackage

`default_nettype wire

// File: sv/hpp_in_if.sv
// ----------------------------------------------------------------------------
// hpp_in_if
// Input byte channel: valid/ready with one packet byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: sv/hpp_out_if.sv
// ----------------------------------------------------------------------------
// hpp_out_if
// Result channel: valid/ready with the parsed greeting fields per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_status;
  logic [7:0]  version_seen;
  logic [7:0]  version_text_length;
  logic [31:0] connection_number;
  logic [63:0] auth_bytes;
  logic [31:0] capability_word;
  logic [7:0]  character_set;
  logic [15:0] server_status_word;

  modport source (
    output valid, output result_status, output version_seen,
    output version_text_length, output connection_number, output auth_bytes,
    output capability_word, output character_set, output server_status_word,
    input ready
  );
  modport sink (
    input valid, input result_status, input version_seen,
    input version_text_length, input connection_number, input auth_bytes,
    input capability_word, input character_set, input server_status_word,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/hpp_parse_core.sv
// ----------------------------------------------------------------------------
// hpp_parse_core
// Per-packet parse state: walks the greeting fields one byte per cycle while
// bytes are taken, and forms the result and status on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_parse_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hpp_pkg::ctl_t ctl,
  input  wire logic [7:0]    expected_version,
  output hpp_pkg::res_t      res
);

  localparam logic [hpp_pkg::STR_LEN_W-1:0] STR_MAX =
    hpp_pkg::STR_LEN_W'(hpp_pkg::VERSION_LEN_MAX);
  localparam logic [hpp_pkg::STR_LEN_W-1:0] TXT_MAX = hpp_pkg::STR_LEN_W'(255);
  localparam logic [hpp_pkg::BYTE_CNT_W-1:0] N_LEN = hpp_pkg::BYTE_CNT_W'(hpp_pkg::LEN_BYTES);
  localparam logic [hpp_pkg::BYTE_CNT_W-1:0] N_HDR = hpp_pkg::BYTE_CNT_W'(hpp_pkg::HDR_BYTES);

  hpp_pkg::phase_t                  phase_r, phase_nxt, phase_upd;
  logic [hpp_pkg::BYTE_CNT_W-1:0]   boff_r, boff_nxt, boff_upd;
  logic [23:0]                      dlen_r, dlen_nxt, dlen_upd;
  logic [2:0]                       foff_r, foff_nxt, foff_upd;
  logic [hpp_pkg::STR_LEN_W-1:0]    slen_r, slen_nxt, slen_upd;
  logic [7:0]                       ver_r, ver_nxt, ver_upd;
  logic [31:0]                      conn_r, conn_nxt, conn_upd;
  logic [63:0]                      auth_r, auth_nxt, auth_upd;
  logic [31:0]                      caps_r, caps_nxt, caps_upd;
  logic [7:0]                       cset_r, cset_nxt, cset_upd;
  logic [15:0]                      stat_r, stat_nxt, stat_upd;
  hpp_pkg::status_t                 status;

  // field walk for the incoming byte
  always_comb begin
    phase_upd = phase_r;
    dlen_upd  = dlen_r;
    foff_upd  = foff_r;
    slen_upd  = slen_r;
    ver_upd   = ver_r;
    conn_upd  = conn_r;
    auth_upd  = auth_r;
    caps_upd  = caps_r;
    cset_upd  = cset_r;
    stat_upd  = stat_r;
    case (phase_r)
      hpp_pkg::PH_HEADER: begin
        if (boff_r < N_LEN) begin
          dlen_upd[{boff_r[1:0], 3'b000} +: 8] = ctl.data;
        end else begin
          phase_upd = hpp_pkg::PH_VERSION;
        end
      end
      hpp_pkg::PH_VERSION: begin
        ver_upd   = ctl.data;
        phase_upd = hpp_pkg::PH_STRING;
      end
      hpp_pkg::PH_STRING: begin
        if (ctl.data == 8'd0) begin
          phase_upd = hpp_pkg::PH_CONN;
          foff_upd  = 3'd0;
        end else if (slen_r < STR_MAX) begin
          slen_upd = slen_r + 1'b1;
        end
      end
      hpp_pkg::PH_CONN: begin
        conn_upd[{foff_r[1:0], 3'b000} +: 8] = ctl.data;
        if (foff_r[1:0] == 2'd3) begin
          foff_upd  = 3'd0;
          phase_upd = hpp_pkg::PH_AUTH;
        end else begin
          foff_upd = foff_r + 3'd1;
        end
      end
      hpp_pkg::PH_AUTH: begin
        auth_upd[{foff_r, 3'b000} +: 8] = ctl.data;
        if (foff_r == 3'd7) begin
          foff_upd  = 3'd0;
          phase_upd = hpp_pkg::PH_FILLER;
        end else begin
          foff_upd = foff_r + 3'd1;
        end
      end
      hpp_pkg::PH_FILLER: begin
        phase_upd = hpp_pkg::PH_CAPLO;
      end
      hpp_pkg::PH_CAPLO: begin
        caps_upd[{1'b0, foff_r[0], 3'b000} +: 8] = ctl.data;
        if (foff_r[0]) begin
          foff_upd  = 3'd0;
          phase_upd = hpp_pkg::PH_CHARSET;
        end else begin
          foff_upd = 3'd1;
        end
      end
      hpp_pkg::PH_CHARSET: begin
        cset_upd  = ctl.data;
        phase_upd = hpp_pkg::PH_STATUS;
      end
      hpp_pkg::PH_STATUS: begin
        stat_upd[{foff_r[0], 3'b000} +: 8] = ctl.data;
        if (foff_r[0]) begin
          foff_upd  = 3'd0;
          phase_upd = hpp_pkg::PH_CAPHI;
        end else begin
          foff_upd = 3'd1;
        end
      end
      hpp_pkg::PH_CAPHI: begin
        caps_upd[{1'b1, foff_r[0], 3'b000} +: 8] = ctl.data;
        if (foff_r[0]) begin
          foff_upd  = 3'd0;
          phase_upd = hpp_pkg::PH_DONE;
        end else begin
          foff_upd = 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // saturating byte count
  assign boff_upd = (boff_r != hpp_pkg::BYTE_CNT_MAX) ? boff_r + 1'b1 : boff_r;

  // status by precedence
  always_comb begin
    if (boff_upd < N_HDR) begin
      status = hpp_pkg::ST_TRUNCATED;
    end else if ({1'b0, dlen_upd} != boff_upd - N_HDR) begin
      status = hpp_pkg::ST_LEN_ERR;
    end else if (boff_upd == N_HDR) begin
      status = hpp_pkg::ST_TRUNCATED;
    end else if (ver_upd != expected_version) begin
      status = hpp_pkg::ST_BAD_VER;
    end else if (phase_upd == hpp_pkg::PH_STRING) begin
      status = hpp_pkg::ST_NO_TERM;
    end else if (phase_upd != hpp_pkg::PH_DONE) begin
      status = hpp_pkg::ST_TRUNCATED;
    end else begin
      status = hpp_pkg::ST_OK;
    end
  end

  // result word for the final byte
  always_comb begin
    res.result_status       = status;
    res.version_seen        = ver_upd;
    res.version_text_length = (slen_upd > TXT_MAX) ? 8'hFF : 8'(slen_upd);
    res.connection_number   = conn_upd;
    res.auth_bytes          = auth_upd;
    res.capability_word     = caps_upd;
    res.character_set       = cset_upd;
    res.server_status_word  = stat_upd;
  end

  // next state: hold, advance, or clear after the final byte
  always_comb begin
    phase_nxt = phase_r;
    boff_nxt  = boff_r;
    dlen_nxt  = dlen_r;
    foff_nxt  = foff_r;
    slen_nxt  = slen_r;
    ver_nxt   = ver_r;
    conn_nxt  = conn_r;
    auth_nxt  = auth_r;
    caps_nxt  = caps_r;
    cset_nxt  = cset_r;
    stat_nxt  = stat_r;
    if (ctl.take && ctl.fin) begin
      phase_nxt = hpp_pkg::PH_HEADER;
      boff_nxt  = '0;
      dlen_nxt  = '0;
      foff_nxt  = '0;
      slen_nxt  = '0;
      ver_nxt   = '0;
      conn_nxt  = '0;
      auth_nxt  = '0;
      caps_nxt  = '0;
      cset_nxt  = '0;
      stat_nxt  = '0;
    end else if (ctl.take) begin
      phase_nxt = phase_upd;
      boff_nxt  = boff_upd;
      dlen_nxt  = dlen_upd;
      foff_nxt  = foff_upd;
      slen_nxt  = slen_upd;
      ver_nxt   = ver_upd;
      conn_nxt  = conn_upd;
      auth_nxt  = auth_upd;
      caps_nxt  = caps_upd;
      cset_nxt  = cset_upd;
      stat_nxt  = stat_upd;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hpp_pkg::PH_HEADER;
      boff_r  <= '0;
      dlen_r  <= '0;
      foff_r  <= '0;
      slen_r  <= '0;
      ver_r   <= '0;
      conn_r  <= '0;
      auth_r  <= '0;
      caps_r  <= '0;
      cset_r  <= '0;
      stat_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      boff_r  <= boff_nxt;
      dlen_r  <= dlen_nxt;
      foff_r  <= foff_nxt;
      slen_r  <= slen_nxt;
      ver_r   <= ver_nxt;
      conn_r  <= conn_nxt;
      auth_r  <= auth_nxt;
      caps_r  <= caps_nxt;
      cset_r  <= cset_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/hpp_out_stage.sv
// ----------------------------------------------------------------------------
// hpp_out_stage
// Result register: holds one parsed greeting word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire hpp_pkg::res_t res,
  output logic               free,
  hpp_out_if.source          out_if
);

  logic          out_vld_r, out_vld_nxt;
  hpp_pkg::res_t res_r;

  // slot can take a new word when empty or draining this cycle
  assign free = !out_vld_r || out_if.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid               = out_vld_r;
  assign out_if.result_status       = res_r.result_status;
  assign out_if.version_seen        = res_r.version_seen;
  assign out_if.version_text_length = res_r.version_text_length;
  assign out_if.connection_number   = res_r.connection_number;
  assign out_if.auth_bytes          = res_r.auth_bytes;
  assign out_if.capability_word     = res_r.capability_word;
  assign out_if.character_set       = res_r.character_set;
  assign out_if.server_status_word  = res_r.server_status_word;

endmodule

`default_nettype wire

// File: sv/handshake_packet_parser.sv
// ----------------------------------------------------------------------------
// handshake_packet_parser
// Server greeting parser: one packet byte per word in, one result word out
// per packet, on the word that carries the final byte flag.
// ----------------------------------------------------------------------------
// Path: final byte held in the input register, result in the result register.
// Throughput: one byte per cycle; a final byte waits in the input register
// only while the result register still holds an untaken word.
// Reset (rst_n low, synchronous): parse state, valids cleared, expected
// version back to 10.
`default_nettype none

module handshake_packet_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hpp_in_if.sink          in_if,
  hpp_out_if.source       out_if,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  logic          in_vld_r, in_vld_nxt;
  logic [7:0]    in_byte_r;
  logic          in_fin_r;
  logic [7:0]    exp_ver_r;
  logic          out_free;
  logic          consume;
  logic          accept;
  hpp_pkg::ctl_t ctl;
  hpp_pkg::res_t res;

  // expected version register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= hpp_pkg::EXPECTED_VERSION_RST;
    end else if (cfg_wr_en) begin
      exp_ver_r <= cfg_wr_data;
    end
  end

  // input register handshake
  assign consume     = in_vld_r && (!in_fin_r || out_free);
  assign in_if.ready = !in_vld_r || consume;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_if.data_byte;
      in_fin_r  <= in_if.final_byte;
    end
  end

  assign ctl.take = consume;
  assign ctl.fin  = in_fin_r;
  assign ctl.data = in_byte_r;

  hpp_parse_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .expected_version (exp_ver_r),
    .res              (res)
  );

  hpp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (consume && in_fin_r),
    .res    (res),
    .free   (out_free),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

// File: sv/hpp_checker.sv
// ----------------------------------------------------------------------------
// hpp_checker
// Port-level checks for the greeting parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_conn,
  input wire logic [63:0] out_auth
);

  // status code always one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= hpp_pkg::ST_TRUNCATED))
    else $error("result status out of range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a draining result slot never back-pressures the byte stream
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side ready");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_conn) && $stable(out_auth)))
    else $error("stalled result word changed");

endmodule

bind handshake_packet_parser hpp_checker u_hpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.result_status),
  .out_conn   (out_if.connection_number),
  .out_auth   (out_if.auth_bytes)
);

`default_nettype wire
